// File: design/stv_pkg.sv
// shared types, constants and exp table for the softmax temperature core
`timescale 1ns / 1ps
`default_nettype none
package stv_pkg;
    localparam int MAX_LEN = 64;
    localparam int EXP_TABLE_SIZE = 256;
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W = ADDR_W + 1;
    localparam int TIDX_W = $clog2(EXP_TABLE_SIZE);
    localparam int STEP_SHIFT = 12;
    localparam int SUM_W = 24;
    localparam int DIV_NUM_W = 34;
    localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
    localparam logic [63:0] EXP_RATIO_Q32 = 64'd4034748382;
    localparam logic [15:0] INV_TEMP_RESET = 16'd256;

    typedef struct packed {
        logic signed [15:0] activation;
        logic               last_of_vector;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] probability;
        logic        last_result;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EXP,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EMIT
    } state_t;

    function automatic logic [EXP_TABLE_SIZE*17-1:0] build_exp_table();
        logic [EXP_TABLE_SIZE*17-1:0] t;
        logic [63:0] v;
        logic [63:0] e;
        logic [127:0] p;
        t = '0;
        v = 64'd1 << 32;
        for (int k = 0; k < EXP_TABLE_SIZE; k++)
        begin
            e = (v + 64'd32768) >> 16;
            t[k*17 +: 17] = (e > 64'd65536) ? 17'd65536 : e[16:0];
            p = v * EXP_RATIO_Q32 + (128'd1 << 31);
            v = p[95:32];
        end
        return t;
    endfunction

    localparam logic [EXP_TABLE_SIZE*17-1:0] EXP_TABLE = build_exp_table();

    function automatic logic [16:0] exp_rom(input logic [TIDX_W-1:0] idx);
        return EXP_TABLE[int'(idx)*17 +: 17];
    endfunction
endpackage
`default_nettype wire

// File: design/stv_divider.sv
// restoring divider for probability = (e*65536 + sum/2) / sum
`timescale 1ns / 1ps
`default_nettype none
module stv_divider
    import stv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [16:0]      e,
    input  wire logic [SUM_W-1:0] sum,
    output logic                  done,
    output logic [15:0]           quo
);
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [SUM_W:0]       rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [SUM_W:0]       trial;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        trial = {rem_reg[SUM_W-1:0], num_reg[DIV_NUM_W-1]};
        if (go)
        begin
            num_next = {1'b0, e, 16'd0} + {11'd0, sum[SUM_W-1:1]};
            rem_next = '0;
            q_next = '0;
            cnt_next = 6'(DIV_NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, sum})
            begin
                rem_next = trial - {1'b0, sum};
                q_next = {q_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quo = (sum == '0) ? 16'd0 :
                 (q_reg[DIV_NUM_W-1:16] != '0) ? 16'hffff : q_reg[15:0];
endmodule
`default_nettype wire

// File: design/stv_exp_unit.sv
// pipelined exp(-d * inverse_temperature) by table interpolation
`timescale 1ns / 1ps
`default_nettype none
module stv_exp_unit
    import stv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [15:0] delta,
    input  wire logic [15:0] inv_temp,
    output logic [16:0]      e
);
    logic [31:0] a_reg;
    logic [16:0] here_reg, next_reg;
    logic [11:0] f_reg;
    logic        zero_reg;
    logic [19:0] idx;
    logic [29:0] prod;

    assign idx = a_reg[31:STEP_SHIFT];

    always_ff @(posedge clk)
    begin
        a_reg <= delta * inv_temp;
        zero_reg <= idx >= 20'(EXP_TABLE_SIZE);
        here_reg <= exp_rom(idx[TIDX_W-1:0]);
        next_reg <= (idx + 20'd1 < 20'(EXP_TABLE_SIZE)) ?
                    exp_rom(TIDX_W'(idx + 20'd1)) : 17'd0;
        f_reg <= a_reg[STEP_SHIFT-1:0];
    end

    assign prod = ({13'd0, here_reg - next_reg} * {18'd0, f_reg}) + 30'd2048;
    assign e = zero_reg ? 17'd0 : here_reg - prod[28:12];
endmodule
`default_nettype wire

// File: design/softmax_temperature_vector_core.sv
// top level of the softmax with temperature core
// channel | signals                     | handshake
// input   | start, busy, in_beat        | accepted when start && !busy
// result  | out_valid, out_beat         | one cycle per beat, no stall
// config  | cfg_we, cfg_wdata           | written when cfg_we
// loading accepts one element per cycle; the exp pass streams the elements through
// the sample memory read register and the exp pipe; each result then passes through
// divider start, 34 divide steps, done and the result beat. busy is high from
// the last element until the final result beat; results are never stalled.
// reset clears control and sets inverse temperature to 1.0
`timescale 1ns / 1ps
`default_nettype none
module softmax_temperature_vector_core
    import stv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_beat_t  in_beat,
    output logic           out_valid,
    output out_beat_t      out_beat,
    input  wire logic      cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    logic [15:0] sample_mem [MAX_LEN];
    logic [16:0] exp_mem [MAX_LEN];
    logic [15:0] samp_rd_reg;
    logic [16:0] exp_rd_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] wptr_reg, wptr_next;
    logic [2:0] vpipe_reg, vpipe_next;
    logic signed [15:0] max_reg, max_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [15:0] inv_reg;
    logic accept, samp_we, exp_we, div_go, div_done;
    logic [16:0] e_val;
    logic [15:0] delta, quo;
    logic [SUM_W:0] sum_add;

    assign accept = start && !busy;
    assign busy = state_reg != ST_LOAD;
    assign samp_we = accept && (count_reg < CNT_W'(MAX_LEN));
    assign delta = 16'(max_reg - $signed(samp_rd_reg));
    assign exp_we = vpipe_reg[2];
    assign sum_add = {1'b0, sum_reg} + {8'd0, e_val};

    stv_exp_unit u_exp (
        .clk      (clk),
        .delta    (delta),
        .inv_temp (inv_reg),
        .e        (e_val)
    );

    stv_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .e     (exp_rd_reg),
        .sum   (sum_reg),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk)
    begin
        if (samp_we)
            sample_mem[count_reg[ADDR_W-1:0]] <= in_beat.activation;
        samp_rd_reg <= sample_mem[rptr_reg[ADDR_W-1:0]];
        if (exp_we)
            exp_mem[wptr_reg[ADDR_W-1:0]] <= e_val;
        exp_rd_reg <= exp_mem[rptr_next[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        vpipe_next = {vpipe_reg[1:0], 1'b0};
        div_go = 1'b0;
        out_valid = 1'b0;
        out_beat.probability = quo;
        out_beat.last_result = (rptr_reg + CNT_W'(1)) == count_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (samp_we)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (in_beat.activation > max_reg)
                        max_next = in_beat.activation;
                end
                if (accept && in_beat.last_of_vector)
                begin
                    state_next = ST_EXP;
                    rptr_next = '0;
                    wptr_next = '0;
                    sum_next = '0;
                end
            end
            ST_EXP:
            begin
                if (rptr_reg < count_reg)
                begin
                    rptr_next = rptr_reg + CNT_W'(1);
                    vpipe_next[0] = 1'b1;
                end
                if (exp_we)
                begin
                    wptr_next = wptr_reg + CNT_W'(1);
                    sum_next = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
                end
                if (vpipe_reg == '0 && rptr_reg == count_reg)
                begin
                    rptr_next = '0;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                div_go = 1'b1;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                rptr_next = rptr_reg + CNT_W'(1);
                if (out_beat.last_result)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    max_next = -16'sd32768;
                end
                else
                    state_next = ST_DIV_START;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            rptr_reg <= '0;
            wptr_reg <= '0;
            vpipe_reg <= '0;
            max_reg <= -16'sd32768;
            sum_reg <= '0;
            inv_reg <= INV_TEMP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rptr_reg <= rptr_next;
            wptr_reg <= wptr_next;
            vpipe_reg <= vpipe_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
            if (cfg_we)
                inv_reg <= cfg_wdata;
        end
    end
endmodule
`default_nettype wire

// File: design/stv_checker.sv
// port-level checker for the softmax temperature core
`timescale 1ns / 1ps
`default_nettype none
module stv_checker
    import stv_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire in_beat_t  in_beat,
    input wire logic      out_valid,
    input wire out_beat_t out_beat
);
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && in_beat.last_of_vector |=> busy)
        else $error("last beat did not raise busy");
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result beat while idle");
    a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.last_result |=> !busy)
        else $error("busy after final beat");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_beat.last_result |=> !out_valid)
        else $error("result beats back to back");
endmodule

bind softmax_temperature_vector_core stv_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
);
`default_nettype wire
